### rtl/srl_pkg.sv
// serial record loader: shared types, protocol codes and sizing constants
// no dependencies; imported by srl_ctrl, srl_datapath and serial_record_loader

package srl_pkg;

   localparam int BUFFER_DEPTH = 16;
   localparam int CAPACITY     = (BUFFER_DEPTH < 16) ? BUFFER_DEPTH : 16;
   localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int BASE_W  = 17;
   localparam int IDX_W   = 4;
   localparam int VEC_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // input item kinds
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_START   = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] K_TX    = 2'd0;
   localparam logic [KIND_W-1:0] K_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] K_BAUD  = 2'd2;
   localparam logic [KIND_W-1:0] K_LEAVE = 2'd3;

   // protocol characters
   localparam logic [BYTE_W-1:0] CH_ENQ   = 8'h05;
   localparam logic [BYTE_W-1:0] CH_ACK   = 8'h06;
   localparam logic [BYTE_W-1:0] CH_BELL  = 8'h07;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_T     = 8'h54;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WORD_DOUBLING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOVED_VECTOR  = 1'd1;

   typedef enum logic [4:0] {
      S_IDLE, S_ACK, S_BAUD, S_COLON, S_LEN, S_ADDRH, S_ADDRL, S_SUM, S_DATA,
      S_DONE, S_TX_ENQ, S_LEAVE, S_TX_BAUD, S_TX_VHI, S_TX_VLO, S_TX_T,
      S_CHECK, S_WRITE, S_TX_BELL
   } state_type;

   typedef enum logic [2:0] {
      OUT_ENQ, OUT_LEAVE, OUT_BAUD, OUT_VHI, OUT_VLO, OUT_T, OUT_BELL, OUT_WRITE
   } out_sel_type;

   typedef struct packed {
      logic        load_len;
      logic        load_addrh;
      logic        load_addrl;
      logic        load_sum;
      logic        data_byte;
      logic        load_baud;
      logic        out_load;
      out_sel_type out_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic len_zero;
      logic count_hit;
      logic rec_good;
      logic wr_last;
      logic out_free;
   } dp_sts_type;

endpackage

### rtl/srl_ram.sv
// generic single write port ram with registered read
// no dependencies

module srl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/srl_ctrl.sv
// serial record loader controller: protocol phase and result sequencing
// depends on srl_pkg

module srl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [srl_pkg::FUNC_W-1:0]  req_func,
   input  logic [srl_pkg::BYTE_W-1:0]  req_byte,
   input  srl_pkg::dp_sts_type         sts,
   output srl_pkg::ctl_cmd_type        cmd,
   output srl_pkg::state_type          state
);
   import srl_pkg::*;

   state_type state_ff, state_in;
   logic      waiting;
   logic      accept;
   logic      is_byte;

   always_comb begin
      case (state_ff)
         S_IDLE, S_ACK, S_BAUD, S_COLON, S_LEN, S_ADDRH, S_ADDRL, S_SUM, S_DATA,
         S_DONE:  waiting = 1'b1;
         default: waiting = 1'b0;
      endcase
   end

   assign req_tready = waiting;
   assign accept     = req_tvalid && waiting;
   assign is_byte    = (req_func == FUNC_BYTE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_START) state_in = S_TX_ENQ;
         end
         S_ACK: begin
            if (accept && req_func == FUNC_TIMEOUT) state_in = S_LEAVE;
            else if (accept && is_byte) state_in = (req_byte == CH_ACK) ? S_BAUD : S_LEAVE;
         end
         S_BAUD: begin
            if (accept && is_byte) state_in = S_TX_BAUD;
         end
         S_COLON: begin
            if (accept && is_byte && req_byte == CH_COLON) state_in = S_LEN;
         end
         S_LEN: begin
            if (accept && is_byte) state_in = (req_byte == CH_S) ? S_LEAVE : S_ADDRH;
         end
         S_ADDRH: begin
            if (accept && is_byte) state_in = S_ADDRL;
         end
         S_ADDRL: begin
            if (accept && is_byte) state_in = S_SUM;
         end
         S_SUM: begin
            if (accept && is_byte) state_in = sts.len_zero ? S_CHECK : S_DATA;
         end
         S_DATA: begin
            if (accept && is_byte && sts.count_hit) state_in = S_CHECK;
         end
         S_DONE: state_in = S_DONE;
         S_TX_ENQ: begin
            if (sts.out_free) state_in = S_ACK;
         end
         S_LEAVE: begin
            if (sts.out_free) state_in = S_DONE;
         end
         S_TX_BAUD: begin
            if (sts.out_free) state_in = S_TX_VHI;
         end
         S_TX_VHI: begin
            if (sts.out_free) state_in = S_TX_VLO;
         end
         S_TX_VLO: begin
            if (sts.out_free) state_in = S_TX_T;
         end
         S_TX_T, S_TX_BELL: begin
            if (sts.out_free) state_in = S_COLON;
         end
         // the pass through this state also fetches buffer entry 0
         S_CHECK: begin
            if (!sts.rec_good) state_in = S_TX_BELL;
            else if (sts.len_zero) state_in = S_TX_T;
            else state_in = S_WRITE;
         end
         S_WRITE: begin
            if (sts.out_free && sts.wr_last) state_in = S_TX_T;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.out_sel = OUT_ENQ;
      case (state_ff)
         S_BAUD:  cmd.load_baud  = accept && is_byte;
         S_LEN:   cmd.load_len   = accept && is_byte && (req_byte != CH_S);
         S_ADDRH: cmd.load_addrh = accept && is_byte;
         S_ADDRL: cmd.load_addrl = accept && is_byte;
         S_SUM:   cmd.load_sum   = accept && is_byte;
         S_DATA:  cmd.data_byte  = accept && is_byte;
         S_TX_ENQ: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_ENQ;
         end
         S_LEAVE: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_LEAVE;
         end
         S_TX_BAUD: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_BAUD;
         end
         S_TX_VHI: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_VHI;
         end
         S_TX_VLO: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_VLO;
         end
         S_TX_T: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_T;
         end
         S_TX_BELL: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_BELL;
         end
         S_WRITE: begin
            cmd.out_load = sts.out_free;
            cmd.out_sel  = OUT_WRITE;
         end
         default: cmd.out_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

### rtl/srl_datapath.sv
// serial record loader datapath: record fields, checksum, buffer, config and result register
// depends on srl_pkg and srl_ram

module srl_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [srl_pkg::BYTE_W-1:0]     req_byte,
   input  logic                           csr_we,
   input  logic [srl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srl_pkg::CSR_DATA_W-1:0] csr_data,
   input  srl_pkg::ctl_cmd_type           cmd,
   output srl_pkg::dp_sts_type            sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [srl_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);
   import srl_pkg::*;

   logic              doubling_ff, doubling_in;
   logic [VEC_W-1:0]  vector_ff, vector_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [VEC_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] baud_ff, baud_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [BASE_W-1:0] out_base_ff, out_base_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              advance;
   logic [BYTE_W-1:0] total;
   logic [BASE_W-1:0] shifted;
   logic [BASE_W-1:0] base;
   logic              buf_we;
   logic [BYTE_W-1:0] buf_rd_data;
   logic [BUF_AW-1:0] buf_rd_addr;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = cmd.out_load && (cmd.out_sel == OUT_WRITE);
   assign buf_we   = cmd.data_byte && (count_ff < BYTE_W'(CAPACITY));
   // look one entry ahead when a write result leaves, so the next byte is ready
   assign buf_rd_addr = BUF_AW'(advance ? rd_idx_ff + IDX_W'(1) : rd_idx_ff);

   srl_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (BUF_AW'(count_ff)),
      .wr_data (req_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   assign total   = sum_ff + len_ff + addr_ff[15:8] + addr_ff[7:0];
   assign shifted = doubling_ff ? {addr_ff, 1'b0} : {1'b0, addr_ff};
   // address 0 after doubling goes to the moved vector, or to the moved vector plus 4 without doubling
   always_comb begin
      if (shifted == '0) begin
         base = doubling_ff ? {1'b0, vector_ff} : ({1'b0, vector_ff} + BASE_W'(4));
      end else begin
         base = shifted;
      end
   end

   assign sts.len_zero  = (len_ff == '0);
   assign sts.count_hit = ((count_ff + BYTE_W'(1)) == len_ff);
   assign sts.rec_good  = (total == '0) && (len_ff <= BYTE_W'(CAPACITY));
   assign sts.wr_last   = ({{(BYTE_W-IDX_W){1'b0}}, rd_idx_ff} == (len_ff - BYTE_W'(1)));
   assign sts.out_free  = out_free;

   always_comb begin
      doubling_in = doubling_ff;
      vector_in   = vector_ff;
      if (csr_we) begin
         case (csr_index)
            REG_WORD_DOUBLING: doubling_in = csr_data[0];
            REG_MOVED_VECTOR:  vector_in   = csr_data[VEC_W-1:0];
            default:           doubling_in = doubling_ff;
         endcase
      end
   end

   always_comb begin
      len_in    = cmd.load_len ? req_byte : len_ff;
      baud_in   = cmd.load_baud ? req_byte : baud_ff;
      addr_in   = addr_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load_addrh) addr_in = {req_byte, 8'h00};
      if (cmd.load_addrl) addr_in = {addr_ff[15:8], req_byte};
      if (cmd.load_sum) begin
         sum_in    = req_byte;
         count_in  = '0;
         rd_idx_in = '0;
      end
      if (cmd.data_byte) begin
         sum_in   = sum_ff + req_byte;
         count_in = count_ff + BYTE_W'(1);
      end
      if (advance) rd_idx_in = rd_idx_ff + IDX_W'(1);
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_base_in  = out_base_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = K_TX;
         out_data_in  = '0;
         out_base_in  = '0;
         out_idx_in   = '0;
         out_last_in  = 1'b0;
         case (cmd.out_sel)
            OUT_ENQ: begin
               out_data_in = CH_ENQ;
               out_last_in = 1'b1;
            end
            OUT_LEAVE: begin
               out_kind_in = K_LEAVE;
               out_last_in = 1'b1;
            end
            OUT_BAUD: begin
               out_kind_in = K_BAUD;
               out_data_in = baud_ff;
            end
            OUT_VHI: out_data_in = vector_ff[15:8];
            OUT_VLO: out_data_in = vector_ff[7:0];
            OUT_T: begin
               out_data_in = CH_T;
               out_last_in = 1'b1;
            end
            OUT_BELL: begin
               out_data_in = CH_BELL;
               out_last_in = 1'b1;
            end
            OUT_WRITE: begin
               out_kind_in = K_WRITE;
               out_data_in = buf_rd_data;
               out_base_in = base;
               out_idx_in  = rd_idx_ff;
            end
            default: out_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         doubling_ff  <= 1'b0;
         vector_ff    <= '0;
         len_ff       <= '0;
         addr_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         doubling_ff  <= doubling_in;
         vector_ff    <= vector_in;
         len_ff       <= len_in;
         addr_ff      <= addr_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      baud_ff     <= baud_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_base_ff <= out_base_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-BYTE_W-BASE_W-IDX_W){1'b0}},
                        out_idx_ff, out_base_ff, out_data_ff};

endmodule

### rtl/serial_record_loader.sv
// serial record loader top level: one input item per cycle while waiting for a byte or event;
// the first result is loaded from the result state that its item leads to, and after the last byte
// of a record the checksum state comes first. results leave one per cycle while rsp_tready allows:
// a baud byte gives 4 results, a good record of n bytes gives n writes and 'T' after the checksum state.
// synchronous reset clears the phase, record fields, config registers and output valid.
// depends on srl_pkg, srl_ctrl, srl_datapath, srl_ram

module serial_record_loader (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] rx_byte
   input  logic [srl_pkg::FUNC_W-1:0]     req_tuser,  // [1:0] func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] tx_or_data, [24:8] write_base, [28:25] byte_index, [31:29] zero
   output logic [srl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [srl_pkg::KIND_W-1:0]     rsp_tuser,  // [1:0] kind
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [srl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srl_pkg::CSR_DATA_W-1:0] csr_data
);
   import srl_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   state_type   state;

   assign csr_ready = 1'b1;

   srl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_byte   (req_tdata),
      .sts        (sts),
      .cmd        (cmd),
      .state      (state)
   );

   srl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a flash write is always followed by 'T'
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == K_WRITE) |-> !rsp_tlast)
      else $error("flash write marked as last item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != K_WRITE) |-> (rsp_tdata[28:8] == '0))
      else $error("non-write item carries address or index");

   // inputs are taken only while no result is being produced
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && cmd.out_load))
      else $error("input accepted while emitting a result");

   assert property (@(posedge clock) disable iff (reset)
      (state == S_DONE) |=> (state == S_DONE))
      else $error("left the done phase without reset");

endmodule

### tb/sv/tb.sv
// testbench for serial_record_loader: drives received bytes and events, checks every reply
// against an in-bench protocol predictor; depends on srl_pkg and the loader rtl
`timescale 1ns / 1ps

module tb;
   import srl_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 400;
   localparam int RECORD_BYTES = 250;

   typedef enum {
      AWAIT_START, AWAIT_ACK, AWAIT_BAUD, AWAIT_COLON, AWAIT_LEN,
      AWAIT_ADDRH, AWAIT_ADDRL, AWAIT_SUM, IN_DATA, LEFT
   } loader_phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data;
      logic [BASE_W-1:0] base;
      logic [IDX_W-1:0]  idx;
      logic              tail;
   } reply_type;

   class loader_replies_type;
      reply_type        replies_due[$];
      reply_type        batch[$];
      loader_phase_type ld_phase = AWAIT_START;
      bit            dbl_mode = 1'b0;
      logic [15:0]   vec_addr = '0;
      logic [7:0]    rec_len = '0;
      logic [15:0]   rec_addr = '0;
      logic [7:0]    sum = '0;
      logic [7:0]    got = '0;
      logic [7:0]    rec_buf [CAPACITY];
      int            errors = 0;
      int            n_checked = 0;
      int            n_writes = 0;
      int            n_bells = 0;
      int            n_good = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
         if (idx == REG_WORD_DOUBLING) dbl_mode = value[0];
         else if (idx == REG_MOVED_VECTOR) vec_addr = value;
      endfunction

      function void add(logic [KIND_W-1:0] kind, logic [7:0] data,
                        logic [BASE_W-1:0] base, logic [IDX_W-1:0] idx);
         reply_type r;
         r.kind = kind;
         r.data = data;
         r.base = base;
         r.idx  = idx;
         r.tail = 1'b0;
         batch.push_back(r);
      endfunction

      function void close_record();
         logic [7:0]        total;
         logic [BASE_W-1:0] base;
         total = sum + rec_len + rec_addr[15:8] + rec_addr[7:0];
         if (total == 8'h00 && rec_len <= CAPACITY) begin
            base = dbl_mode ? {rec_addr, 1'b0} : {1'b0, rec_addr};
            // relocation test comes after the doubling
            if (base == '0) base = dbl_mode ? {1'b0, vec_addr} : {1'b0, vec_addr} + 17'd4;
            for (int i = 0; i < rec_len; i++) add(K_WRITE, rec_buf[i[3:0]], base, i[3:0]);
            add(K_TX, CH_T, '0, '0);
            n_writes += int'(rec_len);
            n_good++;
         end else begin
            add(K_TX, CH_BELL, '0, '0);
            n_bells++;
         end
         ld_phase = AWAIT_COLON;
      endfunction

      function void predict_replies(logic [FUNC_W-1:0] func, logic [7:0] rx);
         batch.delete();
         case (func)
            FUNC_START:
               if (ld_phase == AWAIT_START) begin
                  add(K_TX, CH_ENQ, '0, '0);
                  ld_phase = AWAIT_ACK;
               end
            FUNC_TIMEOUT:
               if (ld_phase == AWAIT_ACK) begin
                  add(K_LEAVE, '0, '0, '0);
                  ld_phase = LEFT;
               end
            FUNC_BYTE:
               case (ld_phase)
                  AWAIT_ACK:
                     if (rx == CH_ACK) begin
                        ld_phase = AWAIT_BAUD;
                     end else begin
                        add(K_LEAVE, '0, '0, '0);
                        ld_phase = LEFT;
                     end
                  AWAIT_BAUD: begin
                     add(K_BAUD, rx, '0, '0);
                     add(K_TX, vec_addr[15:8], '0, '0);
                     add(K_TX, vec_addr[7:0], '0, '0);
                     add(K_TX, CH_T, '0, '0);
                     ld_phase = AWAIT_COLON;
                  end
                  AWAIT_COLON:
                     if (rx == CH_COLON) ld_phase = AWAIT_LEN;
                  AWAIT_LEN:
                     if (rx == CH_S) begin
                        add(K_LEAVE, '0, '0, '0);
                        ld_phase = LEFT;
                     end else begin
                        rec_len = rx;
                        ld_phase = AWAIT_ADDRH;
                     end
                  AWAIT_ADDRH: begin
                     rec_addr = {rx, 8'h00};
                     ld_phase = AWAIT_ADDRL;
                  end
                  AWAIT_ADDRL: begin
                     rec_addr[7:0] = rx;
                     ld_phase = AWAIT_SUM;
                  end
                  AWAIT_SUM: begin
                     sum = rx;
                     got = '0;
                     if (rec_len == 8'h00) close_record();
                     else ld_phase = IN_DATA;
                  end
                  IN_DATA: begin
                     // overlong records keep only what fits but sum everything
                     if (got < CAPACITY) rec_buf[got[3:0]] = rx;
                     sum = sum + rx;
                     got = got + 8'd1;
                     if (got == rec_len) close_record();
                  end
                  default: ;
               endcase
            default: ;
         endcase
         if (batch.size() > 0) batch[batch.size()-1].tail = 1'b1;
         foreach (batch[i]) replies_due.push_back(batch[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] tdata, logic [KIND_W-1:0] kind,
                                logic tlast);
         reply_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual kind %0h data %0h",
                     $time, kind, tdata);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("kind", 32'(want.kind), 32'(kind));
         compare_field("tx_or_data", 32'(want.data), 32'(tdata[7:0]));
         compare_field("write_base", 32'(want.base), 32'(tdata[24:8]));
         compare_field("byte_index", 32'(want.idx), 32'(tdata[28:25]));
         compare_field("tdata pad", 32'd0, 32'(tdata[31:29]));
         compare_field("tlast", 32'(want.tail), 32'(tlast));
         n_checked++;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   loader_replies_type replies = new();
   int req_quiet = 0;
   int rsp_quiet = 0;
   int rsp_wait = 0;
   int idle_cycles = 0;
   int record_bytes = 0;
   int settings_used = 0;

   serial_record_loader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // random wait, with occasional stretches of none
   function automatic int next_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) quiet = $urandom_range(8, 30);
      return $urandom_range(0, 6);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            replies.check_reply(rsp_tdata, rsp_tuser, rsp_tlast);
            rsp_wait = next_wait(rsp_quiet);
            if (rsp_wait > 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (rsp_wait > 0) rsp_wait--;
            if (rsp_wait == 0) rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // valid stays up when the next item follows with no gap
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [7:0] rx);
      int gap;
      gap = next_wait(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      replies.predict_replies(func, rx);
   endtask

   // events the loader ignores once past the handshake
   task automatic send_stray();
      logic [FUNC_W-1:0] func;
      case ($urandom_range(0, 2))
         0: func = FUNC_TIMEOUT;
         1: func = FUNC_START;
         default: func = FUNC_UNUSED;
      endcase
      send_item(func, 8'($urandom));
   endtask

   task automatic send_record(input int len, input logic [15:0] addr, input bit good);
      logic [7:0] bytes_q[$];
      logic [7:0] data_q[$];
      logic [7:0] len_b;
      logic [7:0] total;
      logic [7:0] cksum;
      logic [7:0] d;
      len_b = 8'(len);
      total = len_b + addr[15:8] + addr[7:0];
      for (int i = 0; i < len; i++) begin
         d = 8'($urandom);
         data_q.push_back(d);
         total = total + d;
      end
      cksum = 8'h00 - total;
      if (!good) cksum = cksum + 8'($urandom_range(1, 255));
      bytes_q = '{CH_COLON, len_b, addr[15:8], addr[7:0], cksum};
      bytes_q = {bytes_q, data_q};
      foreach (bytes_q[i]) begin
         if ($urandom_range(0, 24) == 0) send_stray();
         send_item(FUNC_BYTE, bytes_q[i]);
      end
      record_bytes += bytes_q.size();
   endtask

   // drain every expected reply, then give the pipeline time to go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (replies.replies_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      replies.set_register(idx, value);
   endtask

   task automatic apply_setting(input bit mode, input logic [15:0] vec);
      settle();
      write_register(REG_WORD_DOUBLING, {15'd0, mode});
      write_register(REG_MOVED_VECTOR, vec);
      settings_used++;
   endtask

   initial begin
      int len;
      int pick;
      logic [15:0] addr;
      logic [15:0] noise;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      apply_setting(1'b1, 16'hFFFF);
      send_item(FUNC_BYTE, 8'h00);      // byte before start
      send_item(FUNC_TIMEOUT, 8'hFF);   // timeout before start
      send_item(FUNC_UNUSED, 8'hFF);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_START, 8'h00);     // already started
      send_item(FUNC_BYTE, CH_ACK);
      send_item(FUNC_BYTE, 8'hFF);      // baud divider
      send_item(FUNC_BYTE, 8'hFF);      // junk before colon
      send_record(0, 16'h0000, 1'b1);
      send_record(0, 16'h1234, 1'b0);
      send_record(1, 16'hFFFF, 1'b1);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: apply_setting(1'b0, 16'hFFFF);
            1: apply_setting(1'b0, 16'h0000);
            2: apply_setting(1'b1, 16'h0000);
            default: apply_setting(1'($urandom_range(0, 1)), 16'($urandom));
         endcase
         while (record_bytes < (p + 1) * RECORD_BYTES / 5) begin
            repeat ($urandom_range(0, 2)) begin
               noise = 16'($urandom);
               if (noise[7:0] == CH_COLON) noise = ~noise;
               send_item(FUNC_BYTE, noise[7:0]);
            end
            pick = $urandom_range(0, 7);
            if (pick == 0) len = CAPACITY;
            else if (pick == 1) len = $urandom_range(CAPACITY + 1, 40);
            else len = $urandom_range(0, CAPACITY - 1);
            case ($urandom_range(0, 7))
               0, 1: addr = 16'h0000;
               2: addr = 16'h8000;
               3: addr = 16'hFFFF;
               default: addr = 16'($urandom);
            endcase
            send_record(len, addr, $urandom_range(0, 9) != 0);
         end
      end

      // length 'S' ends the session; all later input is dropped
      send_item(FUNC_BYTE, CH_COLON);
      send_item(FUNC_BYTE, CH_S);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_TIMEOUT, 8'h00);
      send_item(FUNC_BYTE, CH_COLON);
      settle();
      repeat (12) @(posedge clock);

      if (replies.replies_due.size() != 0) begin
         $display("%0t: %0d expected replies never arrived", $time, replies.replies_due.size());
         replies.errors++;
      end
      $display("summary: %0d record bytes over %0d register settings, %0d replies checked",
               record_bytes, settings_used, replies.n_checked);
      $display("summary: %0d good records with %0d flash writes, %0d rejected records",
               replies.n_good, replies.n_writes, replies.n_bells);
      if (replies.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
